FILE: rtl/core/stqe_pkg.sv
// Package for the semaphore task queue engine: codes, widths and defaults.
`timescale 1ns / 1ps

package stqe_pkg;

    // Default sizes of the task table and the semaphore set
    localparam int DEFAULT_NUM_TASKS      = 16;
    localparam int DEFAULT_NUM_SEMAPHORES = 8;

    // Field widths on the stream ports
    localparam int KIND_W     = 2;
    localparam int SEM_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int TASK_W     = 5;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int M_PAD_W    = M_TDATA_W - (STATUS_W + TASK_W + 1 + TASK_W);

    // Largest number of semaphores the index field can reach
    localparam int SEM_REACH  = 1 << SEM_W;

    // Semaphore counter, 6-bit two's complement, saturating
    localparam int CNT_W = 6;
    localparam logic signed [CNT_W-1:0] CNT_MIN   = {1'b1, {(CNT_W-1){1'b0}}};
    localparam logic signed [CNT_W-1:0] CNT_MAX   = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic signed [CNT_W-1:0] CNT_RESET = CNT_W'(1);

    // Command codes
    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTER = 2'd0,
        KIND_START    = 2'd1,
        KIND_P        = 2'd2,
        KIND_V        = 2'd3
    } kind_t;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SLOT  = 2'd1,
        STATUS_NO_READY = 2'd2
    } status_t;

endpackage

FILE: rtl/core/semaphore_task_queue_engine_top.sv
// Semaphore task queue engine: task table, ready queue and counting semaphores.
`timescale 1ns / 1ps

// Each command transfer is handled combinationally: the free-slot priority
// encoder, the linked-list queue updates (ready queue and one wait queue per
// semaphore, all kept with head and tail registers) and the saturating
// semaphore counter settle between the state registers and the result
// register. One command is taken per clock while the result register is empty
// or m_tready is high; the result appears on the m_ side in the cycle after
// the command transfer and the block keeps taking commands while the result
// register is being emptied. Only semaphores below both NUM_SEMAPHORES and
// the reach of the 3-bit index are stored; P and V commands on other indexes
// return an all-zero result. Task ids wider than 5 bits are truncated on the result.
module semaphore_task_queue_engine_top #(
    parameter int NUM_TASKS      = stqe_pkg::DEFAULT_NUM_TASKS,
    parameter int NUM_SEMAPHORES = stqe_pkg::DEFAULT_NUM_SEMAPHORES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Command channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [stqe_pkg::S_TDATA_W-1:0] s_tdata,   // kind[1:0], sem_index[4:2]
    // Result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [stqe_pkg::M_TDATA_W-1:0] m_tdata    // status[1:0], task_out[6:2],
                                                      // switch_now[7], woken_task[12:8]
);

    import stqe_pkg::*;

    localparam int ID_W      = $clog2(NUM_TASKS + 1);
    localparam int SEM_SLOTS = (NUM_SEMAPHORES < SEM_REACH) ? NUM_SEMAPHORES : SEM_REACH;
    localparam int SEM_AW    = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;

    // State registers
    logic [NUM_TASKS:1]              slot_used_reg, slot_used_next;
    logic [ID_W-1:0]                 next_link_reg  [1:NUM_TASKS];
    logic [ID_W-1:0]                 next_link_next [1:NUM_TASKS];
    logic [ID_W-1:0]                 ready_head_reg, ready_head_next;
    logic [ID_W-1:0]                 ready_tail_reg, ready_tail_next;
    logic [ID_W-1:0]                 current_task_reg, current_task_next;
    logic signed [CNT_W-1:0]         sem_count_reg  [SEM_SLOTS];
    logic signed [CNT_W-1:0]         sem_count_next [SEM_SLOTS];
    logic [ID_W-1:0]                 wait_head_reg  [SEM_SLOTS];
    logic [ID_W-1:0]                 wait_head_next [SEM_SLOTS];
    logic [ID_W-1:0]                 wait_tail_reg  [SEM_SLOTS];
    logic [ID_W-1:0]                 wait_tail_next [SEM_SLOTS];

    // Result register
    logic                            m_valid_reg;
    logic [M_TDATA_W-1:0]            m_tdata_reg;

    // Command decode and result fields
    kind_t                           in_kind;
    logic [SEM_W-1:0]                in_sem;
    logic                            sem_hit;
    logic [SEM_AW-1:0]               sem_a;
    logic [ID_W-1:0]                 free_id;
    logic [ID_W-1:0]                 pop_id;
    logic signed [CNT_W-1:0]         cnt;
    status_t                         res_status;
    logic [ID_W-1:0]                 res_task;
    logic                            res_switch;
    logic [ID_W-1:0]                 res_woken;
    logic                            s_xfer;

    function automatic logic valid_id(input logic [ID_W-1:0] id);
        return (id != '0) && (32'(id) <= NUM_TASKS);
    endfunction

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_kind = kind_t'(s_tdata[KIND_W-1:0]);
    assign in_sem  = s_tdata[KIND_W+SEM_W-1:KIND_W];
    assign sem_hit = 32'(in_sem) < NUM_SEMAPHORES;
    assign sem_a   = SEM_AW'(in_sem);

    // Lowest free task slot, 0 when the table is full
    always_comb begin
        free_id = '0;
        for (int i = NUM_TASKS; i >= 1; i--) begin
            if (!slot_used_reg[i]) begin
                free_id = ID_W'(i);
            end
        end
    end

    // Command execution: queue and counter updates for one transfer
    always_comb begin
        slot_used_next    = slot_used_reg;
        next_link_next    = next_link_reg;
        ready_head_next   = ready_head_reg;
        ready_tail_next   = ready_tail_reg;
        current_task_next = current_task_reg;
        sem_count_next    = sem_count_reg;
        wait_head_next    = wait_head_reg;
        wait_tail_next    = wait_tail_reg;
        pop_id            = '0;
        cnt               = sem_count_reg[sem_a];
        res_status        = STATUS_OK;
        res_task          = '0;
        res_switch        = 1'b0;
        res_woken         = '0;

        case (in_kind)
            KIND_REGISTER: begin
                if (free_id == '0) begin
                    res_status = STATUS_NO_SLOT;
                end else begin
                    slot_used_next[free_id] = 1'b1;
                    // push onto the ready queue
                    next_link_next[free_id] = '0;
                    if (!valid_id(ready_head_next)) begin
                        ready_head_next = free_id;
                    end else if (valid_id(ready_tail_next)) begin
                        next_link_next[ready_tail_next] = free_id;
                    end
                    ready_tail_next = free_id;
                    res_task = free_id;
                end
            end
            KIND_START: begin
                // pop the ready queue
                if (valid_id(ready_head_next)) begin
                    pop_id = ready_head_next;
                    ready_head_next = next_link_next[pop_id];
                    next_link_next[pop_id] = '0;
                    if (!valid_id(ready_head_next)) begin
                        ready_head_next = '0;
                        ready_tail_next = '0;
                    end
                end else begin
                    ready_head_next = '0;
                    ready_tail_next = '0;
                end
                if (pop_id == '0) begin
                    res_status = STATUS_NO_READY;
                end else begin
                    current_task_next = pop_id;
                    res_task   = pop_id;
                    res_switch = 1'b1;
                end
            end
            KIND_P: begin
                if (sem_hit && valid_id(current_task_reg)) begin
                    if (cnt != CNT_MIN) begin
                        cnt = cnt - CNT_W'(1);
                    end
                    sem_count_next[sem_a] = cnt;
                    if (cnt[CNT_W-1]) begin
                        // park the current task on the wait queue
                        next_link_next[current_task_reg] = '0;
                        if (!valid_id(wait_head_next[sem_a])) begin
                            wait_head_next[sem_a] = current_task_reg;
                        end else if (valid_id(wait_tail_next[sem_a])) begin
                            next_link_next[wait_tail_next[sem_a]] = current_task_reg;
                        end
                        wait_tail_next[sem_a] = current_task_reg;
                        // next ready task becomes current
                        if (valid_id(ready_head_next)) begin
                            pop_id = ready_head_next;
                            ready_head_next = next_link_next[pop_id];
                            next_link_next[pop_id] = '0;
                            if (!valid_id(ready_head_next)) begin
                                ready_head_next = '0;
                                ready_tail_next = '0;
                            end
                        end else begin
                            ready_head_next = '0;
                            ready_tail_next = '0;
                        end
                        current_task_next = pop_id;
                        if (pop_id == '0) begin
                            res_status = STATUS_NO_READY;
                        end else begin
                            res_task   = pop_id;
                            res_switch = 1'b1;
                        end
                    end
                end
            end
            KIND_V: begin
                if (sem_hit && (cnt != CNT_MAX)) begin
                    cnt = cnt + CNT_W'(1);
                    sem_count_next[sem_a] = cnt;
                    if (cnt[CNT_W-1] || (cnt == '0)) begin
                        // pop the wait queue
                        if (valid_id(wait_head_next[sem_a])) begin
                            pop_id = wait_head_next[sem_a];
                            wait_head_next[sem_a] = next_link_next[pop_id];
                            next_link_next[pop_id] = '0;
                            if (!valid_id(wait_head_next[sem_a])) begin
                                wait_head_next[sem_a] = '0;
                                wait_tail_next[sem_a] = '0;
                            end
                        end else begin
                            wait_head_next[sem_a] = '0;
                            wait_tail_next[sem_a] = '0;
                        end
                        // woken task goes to the tail of the ready queue
                        if (pop_id != '0) begin
                            next_link_next[pop_id] = '0;
                            if (!valid_id(ready_head_next)) begin
                                ready_head_next = pop_id;
                            end else if (valid_id(ready_tail_next)) begin
                                next_link_next[ready_tail_next] = pop_id;
                            end
                            ready_tail_next = pop_id;
                            res_woken = pop_id;
                        end
                    end
                end
            end
            default: begin
                res_status = STATUS_OK;
            end
        endcase
    end

    // State update on each command transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_used_reg    <= '0;
            ready_head_reg   <= '0;
            ready_tail_reg   <= '0;
            current_task_reg <= '0;
            for (int i = 1; i <= NUM_TASKS; i++) begin
                next_link_reg[i] <= '0;
            end
            for (int s = 0; s < SEM_SLOTS; s++) begin
                sem_count_reg[s] <= CNT_RESET;
                wait_head_reg[s] <= '0;
                wait_tail_reg[s] <= '0;
            end
        end else if (s_xfer) begin
            slot_used_reg    <= slot_used_next;
            next_link_reg    <= next_link_next;
            ready_head_reg   <= ready_head_next;
            ready_tail_reg   <= ready_tail_next;
            current_task_reg <= current_task_next;
            sem_count_reg    <= sem_count_next;
            wait_head_reg    <= wait_head_next;
            wait_tail_reg    <= wait_tail_next;
        end
    end

    // Result register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, TASK_W'(res_woken), res_switch,
                            TASK_W'(res_task), res_status};
        end
    end

    // Every command transfer leaves a result in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_tvalid)
        else $error("result missing after command transfer");

    // A context switch is only requested with status ok and a real task
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[STATUS_W+TASK_W]) |->
            ((m_tdata[STATUS_W-1:0] == STATUS_OK) &&
             (m_tdata[STATUS_W+TASK_W-1:STATUS_W] != '0)))
        else $error("switch without a target task");

    // Ready queue head and tail are empty together
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ready_head_reg == '0) == (ready_tail_reg == '0))
        else $error("ready queue head and tail disagree");

    // Current task id stays inside the task table
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(current_task_reg) <= NUM_TASKS)
        else $error("current task out of range");

endmodule

FILE: bench/semaphore_task_queue_engine_top_tb.sv
// Self-checking bench for the semaphore task queue engine: directed and random command streams.
`timescale 1ns / 1ps

module semaphore_task_queue_engine_top_tb;

    import stqe_pkg::*;

    localparam int NT      = DEFAULT_NUM_TASKS;
    localparam int NS      = DEFAULT_NUM_SEMAPHORES;
    // list index of the ready queue; wait queues use the semaphore index
    localparam int READY_Q = SEM_REACH;
    localparam int RANDOM_ITEMS = 380;
    localparam int QUIET_AFTER  = 320;

    typedef struct {
        status_t           status;
        logic [TASK_W-1:0] task_id;
        logic              switch_now;
        logic [TASK_W-1:0] woken;
    } outcome_t;

    // Scheduler state tracker and result checker
    class sched_tracker;
        bit                      slot_used [1:NT];
        logic [TASK_W-1:0]       next_link [0:NT];
        logic [TASK_W-1:0]       heads [0:READY_Q];
        logic [TASK_W-1:0]       tails [0:READY_Q];
        logic signed [CNT_W-1:0] counts [0:SEM_REACH-1];
        logic [TASK_W-1:0]       current;
        outcome_t                outcome_q [$];
        int                      errors;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            foreach (next_link[i]) next_link[i] = '0;
            foreach (heads[i]) begin
                heads[i] = '0;
                tails[i] = '0;
            end
            foreach (counts[i]) counts[i] = CNT_RESET;
            current = '0;
            errors  = 0;
        endfunction

        function bit is_task(logic [TASK_W-1:0] id);
            return id >= 1 && id <= NT;
        endfunction

        function void list_push(int q, logic [TASK_W-1:0] id);
            if (!is_task(id)) return;
            next_link[id] = '0;
            if (!is_task(heads[q])) heads[q] = id;
            else if (is_task(tails[q])) next_link[tails[q]] = id;
            tails[q] = id;
        endfunction

        function logic [TASK_W-1:0] list_pop(int q);
            logic [TASK_W-1:0] id;
            id = heads[q];
            if (!is_task(id)) begin
                heads[q] = '0;
                tails[q] = '0;
                return '0;
            end
            heads[q] = next_link[id];
            next_link[id] = '0;
            if (!is_task(heads[q])) begin
                heads[q] = '0;
                tails[q] = '0;
            end
            return id;
        endfunction

        function int ready_len();
            int n;
            logic [TASK_W-1:0] id;
            n  = 0;
            id = heads[READY_Q];
            while (is_task(id) && n <= NT) begin
                n++;
                id = next_link[id];
            end
            return n;
        endfunction

        // Apply one accepted command; returns 0 when the block ignores a P command
        function bit log_command(kind_t k, logic [SEM_W-1:0] s);
            outcome_t          o;
            int                found;
            logic [TASK_W-1:0] id;
            bit                effective;
            o.status     = STATUS_OK;
            o.task_id    = '0;
            o.switch_now = 1'b0;
            o.woken      = '0;
            effective    = 1'b1;
            found        = 0;
            case (k)
                KIND_REGISTER: begin
                    for (int i = 1; i <= NT; i++)
                        if (!slot_used[i] && found == 0) found = i;
                    if (found == 0) begin
                        o.status = STATUS_NO_SLOT;
                    end else begin
                        slot_used[found] = 1'b1;
                        list_push(READY_Q, TASK_W'(found));
                        o.task_id = TASK_W'(found);
                    end
                end
                KIND_START: begin
                    id = list_pop(READY_Q);
                    if (id == 0) begin
                        o.status = STATUS_NO_READY;
                    end else begin
                        current      = id;
                        o.task_id    = id;
                        o.switch_now = 1'b1;
                    end
                end
                KIND_P: begin
                    if (s >= NS || !is_task(current)) begin
                        effective = 1'b0;
                    end else begin
                        if (counts[s] > CNT_MIN) counts[s]--;
                        // blocking: park current task, run next ready one
                        if (counts[s] < 0) begin
                            list_push(s, current);
                            id = list_pop(READY_Q);
                            current = id;
                            if (id == 0) begin
                                o.status = STATUS_NO_READY;
                            end else begin
                                o.task_id    = id;
                                o.switch_now = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    // V saturates at the top; a waiter goes to the ready tail
                    if (s < NS && counts[s] < CNT_MAX) begin
                        counts[s]++;
                        if (counts[s] <= 0) begin
                            id = list_pop(s);
                            if (id != 0) begin
                                list_push(READY_Q, id);
                                o.woken = id;
                            end
                        end
                    end
                end
            endcase
            outcome_q.push_back(o);
            return effective;
        endfunction

        task report_mismatch(string what, int exp_v, int got_v);
            errors++;
            if (errors <= 30)
                $display("[%0t] mismatch on %s: expected %0d, got %0d",
                         $time, what, exp_v, got_v);
        endtask

        task check_outcome(logic [M_TDATA_W-1:0] d);
            outcome_t e;
            if (outcome_q.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", 0, d);
                return;
            end
            e = outcome_q.pop_front();
            if (d[1:0] !== e.status)     report_mismatch("status", e.status, d[1:0]);
            if (d[6:2] !== e.task_id)    report_mismatch("task_out", e.task_id, d[6:2]);
            if (d[7] !== e.switch_now)   report_mismatch("switch_now", e.switch_now, d[7]);
            if (d[12:8] !== e.woken)     report_mismatch("woken_task", e.woken, d[12:8]);
        endtask

        task finish_check();
            if (outcome_q.size() != 0)
                report_mismatch("results still outstanding", 0, outcome_q.size());
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // kind[1:0], sem_index[4:2]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // status[1:0], task_out[6:2], switch_now[7],
                                      // woken_task[12:8]

    sched_tracker sched;
    int           idle_pct;
    int           counted;

    semaphore_task_queue_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2000000;
        $display("semaphore_task_queue_engine_top_tb failed");
        $finish;
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sched.check_outcome(m_tdata);
    end

    // Result-side backpressure in short bursts
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // One command transfer, with an optional idle burst in front
    task automatic send_cmd(kind_t k, logic [SEM_W-1:0] s);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 3);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - KIND_W - SEM_W){1'b0}}, s, k};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        void'(sched.log_command(k, s));
        counted++;
    endtask

    // Stop sending and wait for every pending result
    task automatic hold_until_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sched.outcome_q.size() != 0) @(posedge aclk);
    endtask

    // Command choice biased by the scheduler state
    function automatic kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (!sched.is_task(sched.current)) begin
            if (r < 50) return KIND_START;
            if (r < 60) return KIND_P;
            if (r < 95) return KIND_V;
            return KIND_REGISTER;
        end
        if (r < 1)  return KIND_START;
        if (r < 47) return KIND_P;
        if (r < 92) return KIND_V;
        return KIND_REGISTER;
    endfunction

    // Mostly a few hot semaphores so that wait queues build up
    function automatic logic [SEM_W-1:0] pick_sem();
        if ($urandom_range(0, 9) < 7) return SEM_W'($urandom_range(0, 2));
        return SEM_W'($urandom_range(0, SEM_REACH - 1));
    endfunction

    // Stimulus
    initial begin
        int               base;
        int               r;
        int               n;
        logic [SEM_W-1:0] s;
        sched    = new();
        idle_pct = 20;
        counted  = 0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        aresetn  = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty queues, table fill and overflow, block and wake
        send_cmd(KIND_START, '0);
        send_cmd(KIND_P, '0);
        send_cmd(KIND_V, SEM_W'(SEM_REACH - 1));
        for (int i = 0; i < NT; i++) send_cmd(KIND_REGISTER, SEM_W'(i));
        send_cmd(KIND_REGISTER, '1);
        send_cmd(KIND_START, '0);
        send_cmd(KIND_P, '0);
        send_cmd(KIND_P, '0);
        send_cmd(KIND_START, '0);
        send_cmd(KIND_V, '0);
        hold_until_idle();

        // Random: saturate one semaphore, then mixed sequences
        base = counted;
        s = SEM_W'($urandom_range(3, SEM_REACH - 1));
        repeat (34) send_cmd(KIND_V, s);
        while (counted - base < RANDOM_ITEMS) begin
            if (counted - base > QUIET_AFTER) begin
                idle_pct = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 2);
                idle_pct = (r == 0) ? 0 : (r == 1) ? 15 : 35;
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                n = $urandom_range(8, 20);
                repeat (n) send_cmd(pick_kind(), pick_sem());
            end else if (r < 88) begin
                // drain the ready queue into one wait queue, then release some
                s = pick_sem();
                n = sched.ready_len() + $urandom_range(1, 3);
                repeat (n) send_cmd(KIND_P, s);
                repeat ($urandom_range(1, n + 2)) send_cmd(KIND_V, s);
            end else if (r < 93) begin
                n = $urandom_range(3, 6);
                repeat (n)
                    send_cmd(kind_t'($urandom_range(0, 3)),
                             SEM_W'($urandom_range(0, SEM_REACH - 1)));
            end else if (r < 97) begin
                hold_until_idle();
            end else if (!sched.is_task(sched.current)) begin
                send_cmd(KIND_START, pick_sem());
            end
        end

        hold_until_idle();
        repeat (4) @(posedge aclk);
        sched.finish_check();
        if (sched.errors == 0) begin
            $display("semaphore_task_queue_engine_top_tb passed");
        end else begin
            $display("semaphore_task_queue_engine_top_tb failed");
        end
        $finish;
    end

endmodule
